// ===== rtl/ordered_dither_pixel_pack_macros.svh =====
// Assertion macros shared by the ordered dither pixel packer checks.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef ORDERED_DITHER_PIXEL_PACK_MACROS_SVH
`define ORDERED_DITHER_PIXEL_PACK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ODPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ODPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/odpp_pkg.sv =====
// Package for the ordered dither pixel packer: format codes, the 4x4 Bayer
// threshold table and the per-channel dither function. No dependencies.
`default_nettype none

package odpp_pkg;

    typedef enum logic [1:0] {
        FMT_RGB332 = 2'd0,
        FMT_RGB555 = 2'd1,
        FMT_RGB565 = 2'd2,
        FMT_PASS   = 2'd3
    } pixel_fmt_t;

    localparam pixel_fmt_t FMT_RESET = FMT_PASS;

    localparam int COLOR_W  = 32;
    localparam int PHASE_W  = 2;
    localparam int S_DATA_W = ((COLOR_W + 2 * PHASE_W + 7) / 8) * 8;
    localparam int PIXEL_W  = 32;

    // Bayer threshold, row = x phase, column = y phase.
    function automatic logic [3:0] bayer_thr(input logic [1:0] row, input logic [1:0] col);
        logic [3:0] thr;
        case ({row, col})
            4'h0: thr = 4'd0;   4'h1: thr = 4'd8;   4'h2: thr = 4'd1;   4'h3: thr = 4'd9;
            4'h4: thr = 4'd12;  4'h5: thr = 4'd4;   4'h6: thr = 4'd13;  4'h7: thr = 4'd5;
            4'h8: thr = 4'd3;   4'h9: thr = 4'd11;  4'ha: thr = 4'd2;   4'hb: thr = 4'd10;
            4'hc: thr = 4'd15;  4'hd: thr = 4'd7;   4'he: thr = 4'd14;  default: thr = 4'd6;
        endcase
        return thr;
    endfunction

    // Truncate an 8-bit channel to keep bits (2..6), round up by one LSB when the
    // next four dropped bits reach the threshold, saturate at all ones.
    function automatic logic [5:0] dither_chan(input logic [7:0] chan, input int keep,
                                               input logic [3:0] thr);
        logic [3:0] drop;
        logic [7:0] kept;
        logic [7:0] full;
        logic [7:0] low;
        logic [3:0] nib;
        drop = 4'(8 - keep);
        kept = chan >> drop;
        full = (8'd1 << keep) - 8'd1;
        low  = chan & ((8'd1 << drop) - 8'd1);
        if (drop >= 4'd4) begin
            nib = 4'(low >> (drop - 4'd4));
        end else begin
            nib = 4'(low << (4'd4 - drop));
        end
        if (kept != full && nib >= thr) begin
            kept = kept + 8'd1;
        end
        return kept[5:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ordered_dither_pixel_pack.sv =====
// Ordered dither pixel packer: one ARGB colour in, one packed display pixel out.
// Depends on odpp_pkg for format codes, the Bayer table and the dither function.
//
// Converts a 32-bit ARGB colour to RGB332, RGB555 or RGB565 with 4x4 Bayer
// ordered dithering, or passes it through unchanged, as selected by the
// pixel_format register written over the cfg port (reset: pass-through). Write
// the format only while no pixel is in flight. The block takes one pixel per
// clock while s_tready is high: the item lands in an input register, the
// dither and pack logic sits between that register and the result register,
// which drives m_tdata. Both stages hold under back-pressure on the result
// side; s_tready drops only when both stages are full and m_tready is low.
`default_nettype none

module ordered_dither_pixel_pack
    import odpp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // Configuration: pixel_format[1:0]
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_data,
    // Input stream, tdata: color[31:0], x_phase[33:32], y_phase[35:34], zero[39:36]
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // Output stream, tdata: pixel[31:0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [PIXEL_W-1:0]       m_tdata
);

    pixel_fmt_t            fmt_reg;
    logic                  in_vld_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic [PHASE_W-1:0]    x_phase_reg;
    logic [PHASE_W-1:0]    y_phase_reg;
    logic                  out_vld_reg;
    logic [PIXEL_W-1:0]    pixel_reg;
    logic [PIXEL_W-1:0]    pixel_next;
    logic                  advance;
    logic [3:0]            thr;
    logic [5:0]            r_q, g_q, b_q;

    assign cfg_ready = 1'b1;
    assign advance   = !out_vld_reg || m_tready;
    assign s_tready  = !in_vld_reg || advance;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = pixel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            fmt_reg <= pixel_fmt_t'(cfg_data);
        end
    end

    // Input register stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            color_reg   <= s_tdata[COLOR_W-1:0];
            x_phase_reg <= s_tdata[COLOR_W +: PHASE_W];
            y_phase_reg <= s_tdata[COLOR_W+PHASE_W +: PHASE_W];
        end
    end

    // Dither and pack
    always_comb begin
        thr        = bayer_thr(x_phase_reg, y_phase_reg);
        r_q        = '0;
        g_q        = '0;
        b_q        = '0;
        pixel_next = color_reg;
        case (fmt_reg)
            FMT_RGB332: begin
                r_q        = dither_chan(color_reg[23:16], 3, thr);
                g_q        = dither_chan(color_reg[15:8], 3, thr);
                b_q        = dither_chan(color_reg[7:0], 2, thr);
                pixel_next = {24'd0, r_q[2:0], g_q[2:0], b_q[1:0]};
            end
            FMT_RGB555: begin
                r_q        = dither_chan(color_reg[23:16], 5, thr);
                g_q        = dither_chan(color_reg[15:8], 5, thr);
                b_q        = dither_chan(color_reg[7:0], 5, thr);
                pixel_next = {17'd0, r_q[4:0], g_q[4:0], b_q[4:0]};
            end
            FMT_RGB565: begin
                r_q        = dither_chan(color_reg[23:16], 5, thr);
                g_q        = dither_chan(color_reg[15:8], 6, thr);
                b_q        = dither_chan(color_reg[7:0], 5, thr);
                pixel_next = {16'd0, r_q[4:0], g_q[5:0], b_q[4:0]};
            end
            default: begin
                pixel_next = color_reg;
            end
        endcase
    end

    // Result register stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_vld_reg) begin
            pixel_reg <= pixel_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/odpp_checker.sv =====
// Port-level checks for ordered_dither_pixel_pack, bound to the top level.
// Depends on odpp_pkg and ordered_dither_pixel_pack_macros.svh.
`default_nettype none

`include "ordered_dither_pixel_pack_macros.svh"

module odpp_checker
    import odpp_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                cfg_valid,
    input wire logic                cfg_ready,
    input wire logic [1:0]          cfg_data,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [PIXEL_W-1:0]  m_tdata
);

    pixel_fmt_t fmt_reg;

    // Track the format as seen on the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            fmt_reg <= pixel_fmt_t'(cfg_data);
        end
    end

    `ODPP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `ODPP_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid && !m_tready, "input stalled without back-pressure")
    `ODPP_ASSERT_NOW(a_narrow_upper, m_tvalid && fmt_reg != FMT_PASS, m_tdata[31:16] == 16'd0, "upper bits set")
    `ODPP_ASSERT_NOW(a_rgb332_upper, m_tvalid && fmt_reg == FMT_RGB332, m_tdata[31:8] == 24'd0, "RGB332 upper bits set")

endmodule

bind ordered_dither_pixel_pack odpp_checker u_odpp_checker (.*);

`default_nettype wire
